[src/wog_pkg.sv]
// ----------------------------------------------------------------------------
// wog_pkg
// Shared types and constants of the WELL1024a record offset generator.
// ----------------------------------------------------------------------------
package wog_pkg;

  localparam int WordW           = 32;
  localparam int PosW            = 5;
  localparam int WordCount       = 32;
  localparam int NumRecW         = 21;
  localparam int SprW            = 16;
  localparam int RecIdxW         = 20;
  localparam int OffsetW         = 36;
  localparam int CfgDataW        = 21;
  localparam int RecordIndexBits = 20;
  localparam int ProdW           = WordW + NumRecW;

  // record count saturates here so the index always fits its field
  localparam logic [NumRecW-1:0] RecordLimit = NumRecW'(1 << RecordIndexBits);

  // WELL1024a taps relative to the current position
  localparam logic [PosW-1:0] Tap1 = PosW'(3);
  localparam logic [PosW-1:0] Tap2 = PosW'(24);
  localparam logic [PosW-1:0] Tap3 = PosW'(10);

  localparam int ShT1  = 8;
  localparam int ShT2  = 19;
  localparam int ShT3  = 14;
  localparam int ShA   = 11;
  localparam int ShB   = 7;
  localparam int ShC   = 13;

  typedef enum logic {
    OpLoad = 1'b0,
    OpGen  = 1'b1
  } opcode_e;

  typedef enum logic {
    CfgNumRecords       = 1'b0,
    CfgSectorsPerRecord = 1'b1
  } cfg_reg_e;

  typedef enum logic {
    CmdLoad = 1'b0,
    CmdStep = 1'b1
  } cmd_kind_e;

  typedef enum logic [2:0] {
    BkIdle,
    BkRead,
    BkWrNew,
    BkWrPrev,
    BkMulRec,
    BkMulOff,
    BkOut
  } back_state_e;

  typedef struct packed {
    opcode_e           opcode;
    logic [PosW-1:0]   seed_index;
    logic [WordW-1:0]  seed_word;
  } in_item_t;

  typedef struct packed {
    logic [WordW-1:0]   random_word;
    logic [RecIdxW-1:0] record_index;
    logic [OffsetW-1:0] sector_offset;
  } out_item_t;

  typedef struct packed {
    cmd_kind_e         kind;
    logic [PosW-1:0]   index;
    logic [WordW-1:0]  word;
  } cmd_t;

  typedef struct packed {
    logic [NumRecW-1:0] num_records;
    logic [SprW-1:0]    sectors_per_record;
  } cfg_t;

  function automatic logic [WordW-1:0] xor_right(input logic [WordW-1:0] v, input int s);
    xor_right = v ^ (v >> s);
  endfunction

  function automatic logic [WordW-1:0] xor_left(input logic [WordW-1:0] v, input int s);
    xor_left = v ^ (v << s);
  endfunction

endpackage

[src/wog_front.sv]
// ----------------------------------------------------------------------------
// wog_front
// Input side: takes requests, classifies them and holds them in a
// two-entry queue for the engine.
// ----------------------------------------------------------------------------
module wog_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  wog_pkg::in_item_t in_item_i,
  output logic              full_o,
  output logic              cmd_valid_o,
  output wog_pkg::cmd_t     cmd_o,
  input  logic              cmd_pop_i
);

  wog_pkg::cmd_t entries_q [2];
  logic          wr_ptr_q, wr_ptr_d;
  logic          rd_ptr_q, rd_ptr_d;
  logic [1:0]    count_q, count_d;
  logic          do_push, do_pop;
  wog_pkg::cmd_t cmd_new;

  assign full_o      = (count_q == 2'd2);
  assign cmd_valid_o = (count_q != 2'd0);
  assign cmd_o       = entries_q[rd_ptr_q];
  assign do_push     = push_i && !full_o;
  assign do_pop      = cmd_pop_i && cmd_valid_o;

  always_comb begin
    cmd_new.kind  = (in_item_i.opcode == wog_pkg::OpGen) ? wog_pkg::CmdStep : wog_pkg::CmdLoad;
    cmd_new.index = in_item_i.seed_index;
    cmd_new.word  = in_item_i.seed_word;
    wr_ptr_d      = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d      = do_pop ? ~rd_ptr_q : rd_ptr_q;
    count_d       = count_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= cmd_new;
    end
  end

endmodule

[src/wog_back.sv]
// ----------------------------------------------------------------------------
// wog_back
// Engine: state memory, WELL1024a step sequencer, record scaling and the
// output register.
// ----------------------------------------------------------------------------
module wog_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  input  wog_pkg::cmd_t      cmd_i,
  output logic               cmd_pop_o,
  input  wog_pkg::cfg_t      cfg_i,
  input  logic               pop_i,
  output logic               empty_o,
  output wog_pkg::out_item_t out_item_o
);

  wog_pkg::back_state_e state_q, state_d;

  logic [wog_pkg::WordW-1:0] mem [wog_pkg::WordCount];
  logic [wog_pkg::WordW-1:0] rdata_q;
  logic                      mem_we, mem_re;
  logic [wog_pkg::PosW-1:0]  mem_waddr, mem_raddr;
  logic [wog_pkg::WordW-1:0] mem_wdata;

  logic [wog_pkg::PosW-1:0]  pos_q;
  logic [wog_pkg::PosW-1:0]  prev;
  logic [2:0]                rd_cnt_q;

  logic [wog_pkg::WordW-1:0] w_p_q, w_t1_q, w_t2_q, w_t3_q, w_prev_q;
  logic [wog_pkg::WordW-1:0] val_b, val_c, new_p, new_prev;
  logic [wog_pkg::WordW-1:0] word_q;

  logic [wog_pkg::NumRecW-1:0] count;
  logic [wog_pkg::ProdW-1:0]   prod_q;
  logic [wog_pkg::RecIdxW-1:0] rec;
  logic [wog_pkg::OffsetW-1:0] offset_q;

  logic                  out_valid_q;
  wog_pkg::out_item_t    out_q;
  logic                  load_out;

  assign prev     = pos_q - wog_pkg::PosW'(1);
  assign val_b    = w_p_q ^ wog_pkg::xor_right(w_t1_q, wog_pkg::ShT1);
  assign val_c    = wog_pkg::xor_left(w_t2_q, wog_pkg::ShT2)
                  ^ wog_pkg::xor_left(w_t3_q, wog_pkg::ShT3);
  assign new_p    = val_b ^ val_c;
  assign new_prev = wog_pkg::xor_left(w_prev_q, wog_pkg::ShA)
                  ^ wog_pkg::xor_left(val_b, wog_pkg::ShB)
                  ^ wog_pkg::xor_left(val_c, wog_pkg::ShC);

  assign count = (cfg_i.num_records > wog_pkg::RecordLimit) ? wog_pkg::RecordLimit
                                                            : cfg_i.num_records;
  assign rec   = prod_q[wog_pkg::WordW +: wog_pkg::RecIdxW];

  assign empty_o    = !out_valid_q;
  assign out_item_o = out_q;

  always_comb begin
    state_d   = state_q;
    cmd_pop_o = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = pos_q;
    mem_wdata = new_p;
    mem_raddr = pos_q;
    load_out  = 1'b0;
    unique case (state_q)
      wog_pkg::BkIdle: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          if (cmd_i.kind == wog_pkg::CmdLoad) begin
            mem_we    = 1'b1;
            mem_waddr = cmd_i.index;
            mem_wdata = cmd_i.word;
          end else begin
            state_d = wog_pkg::BkRead;
          end
        end
      end
      wog_pkg::BkRead: begin
        // five reads issued on counts 0..4, captured on counts 1..5
        mem_re = (rd_cnt_q < 3'd5);
        unique case (rd_cnt_q)
          3'd0:    mem_raddr = pos_q;
          3'd1:    mem_raddr = pos_q + wog_pkg::Tap1;
          3'd2:    mem_raddr = pos_q + wog_pkg::Tap2;
          3'd3:    mem_raddr = pos_q + wog_pkg::Tap3;
          default: mem_raddr = prev;
        endcase
        if (rd_cnt_q == 3'd5) begin
          state_d = wog_pkg::BkWrNew;
        end
      end
      wog_pkg::BkWrNew: begin
        mem_we    = 1'b1;
        mem_waddr = pos_q;
        mem_wdata = new_p;
        state_d   = wog_pkg::BkWrPrev;
      end
      wog_pkg::BkWrPrev: begin
        mem_we    = 1'b1;
        mem_waddr = prev;
        mem_wdata = new_prev;
        state_d   = wog_pkg::BkMulRec;
      end
      wog_pkg::BkMulRec: begin
        state_d = wog_pkg::BkMulOff;
      end
      wog_pkg::BkMulOff: begin
        state_d = wog_pkg::BkOut;
      end
      wog_pkg::BkOut: begin
        if (!out_valid_q || pop_i) begin
          load_out = 1'b1;
          state_d  = wog_pkg::BkIdle;
        end
      end
      default: begin
        state_d = wog_pkg::BkIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= wog_pkg::BkIdle;
      pos_q       <= '0;
      rd_cnt_q    <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == wog_pkg::BkIdle) begin
        rd_cnt_q <= 3'd0;
        if (cmd_valid_i && cmd_i.kind == wog_pkg::CmdLoad) begin
          pos_q <= '0;
        end
      end else if (state_q == wog_pkg::BkRead) begin
        rd_cnt_q <= rd_cnt_q + 3'd1;
      end else if (state_q == wog_pkg::BkWrPrev) begin
        pos_q <= prev;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // state memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == wog_pkg::BkRead) begin
      unique case (rd_cnt_q)
        3'd1:    w_p_q    <= rdata_q;
        3'd2:    w_t1_q   <= rdata_q;
        3'd3:    w_t2_q   <= rdata_q;
        3'd4:    w_t3_q   <= rdata_q;
        3'd5:    w_prev_q <= rdata_q;
        default: ;
      endcase
    end
    if (state_q == wog_pkg::BkWrPrev) begin
      word_q <= new_prev;
    end
    if (state_q == wog_pkg::BkMulRec) begin
      prod_q <= wog_pkg::ProdW'(word_q) * wog_pkg::ProdW'(count);
    end
    if (state_q == wog_pkg::BkMulOff) begin
      offset_q <= wog_pkg::OffsetW'(rec) * wog_pkg::OffsetW'(cfg_i.sectors_per_record);
    end
    if (load_out) begin
      out_q.random_word   <= word_q;
      out_q.record_index  <= rec;
      out_q.sector_offset <= offset_q;
    end
  end

endmodule

[src/well1024a_offset_generator.sv]
// ----------------------------------------------------------------------------
// well1024a_offset_generator
// WELL1024a generator that maps each new word to a random record index and
// its sector offset.
// ----------------------------------------------------------------------------
// Sequence: a taken generate request reads five state words, writes two,
//   runs the record and offset multiplies and loads the output register once
//   it is empty or popped; no request is taken before that, paced by the state
//   memory's single read port. A load writes its word and gives no result.
// Reset: position 0, num_records 1, sectors_per_record 2, queues empty; the
//   32 state words are undefined until loaded.
module well1024a_offset_generator (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push,
  input  wog_pkg::in_item_t               in_item_i,
  output logic                            full,
  input  logic                            pop,
  output logic                            empty,
  output wog_pkg::out_item_t              out_item_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wog_pkg::cfg_reg_e               cfg_index_i,
  input  logic [wog_pkg::CfgDataW-1:0]    cfg_data_i
);

  wog_pkg::cfg_t cfg_q;
  logic          cmd_valid;
  wog_pkg::cmd_t cmd;
  logic          cmd_pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.num_records        <= wog_pkg::NumRecW'(1);
      cfg_q.sectors_per_record <= wog_pkg::SprW'(2);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        wog_pkg::CfgNumRecords:
          cfg_q.num_records <= cfg_data_i[wog_pkg::NumRecW-1:0];
        wog_pkg::CfgSectorsPerRecord:
          cfg_q.sectors_per_record <= cfg_data_i[wog_pkg::SprW-1:0];
        default: ;
      endcase
    end
  end

  wog_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .in_item_i   (in_item_i),
    .full_o      (full),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  wog_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .cfg_i       (cfg_q),
    .pop_i       (pop),
    .empty_o     (empty),
    .out_item_o  (out_item_o)
  );

endmodule
